FILE: hdl/rvalu_pkg.sv
// Shared types, codes and bit-serial arithmetic steps of the residue vector ALU.
`default_nettype none
package rvalu_pkg;

  localparam int unsigned LaneSlots = 8;
  localparam int unsigned ResW      = 31;

  // Item kinds carried in tuser
  localparam logic [3:0] KIND_CLR = 4'd0;
  localparam logic [3:0] KIND_LD  = 4'd1;
  localparam logic [3:0] KIND_DIG = 4'd2;
  localparam logic [3:0] KIND_ADD = 4'd3;
  localparam logic [3:0] KIND_SUB = 4'd4;
  localparam logic [3:0] KIND_MUL = 4'd5;
  localparam logic [3:0] KIND_DIV = 4'd6;
  localparam logic [3:0] KIND_CMP = 4'd7;
  localparam logic [3:0] KIND_RD  = 4'd8;

  localparam logic [ResW-1:0] ModReset [LaneSlots] = '{
    31'd2147483647, 31'd2147483629, 31'd2147483587, 31'd2147483579,
    31'd2147483563, 31'd2147483549, 31'd2147483543, 31'd2147483497
  };

  typedef struct packed {
    logic            last_result;
    logic            a_less_than_b;
    logic            banks_equal;
    logic [ResW-1:0] residue;
    logic [2:0]      lane_index;
  } res_t;

  // r = (2r + b) mod m, r < m
  function automatic logic [ResW-1:0] red_step(logic [ResW-1:0] r, logic b,
                                               logic [ResW-1:0] m);
    logic [ResW:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[ResW-1:0];
  endfunction

  // Horner step of a modular product: r = (2r + b*a) mod m
  function automatic logic [ResW-1:0] mm_step(logic [ResW-1:0] r, logic b,
                                              logic [ResW-1:0] a,
                                              logic [ResW-1:0] m);
    logic [ResW:0] u;
    logic [ResW:0] v;
    u = {r, 1'b0};
    if (u >= {1'b0, m}) u = u - {1'b0, m};
    v = u;
    if (b) v = u + {1'b0, a};
    if (v >= {1'b0, m}) v = v - {1'b0, m};
    return v[ResW-1:0];
  endfunction

  function automatic logic [ResW-1:0] add_mod(logic [ResW-1:0] a, logic [ResW-1:0] b,
                                              logic [ResW-1:0] m);
    logic [ResW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[ResW-1:0];
  endfunction

  function automatic logic [ResW-1:0] sub_mod(logic [ResW-1:0] a, logic [ResW-1:0] b,
                                              logic [ResW-1:0] m);
    logic [ResW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    return s[ResW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/residue_vector_alu_core.sv
// Top level of the residue vector ALU: lane sequencer and bit-serial datapath.
`default_nettype none
// Two banks of residues (A, B), one per lane, each lane with its own modulus
// register. Lanes are handled one after another by a single bit-serial unit
// that moves one bit per cycle. Per lane: load is a 64-bit serial reduction;
// digit append is a 31-bit reduction of the stored residue, then a 64-bit
// reduction of h*10+d; div runs Euclid steps (up to about 45 for 31-bit
// moduli), each step a restoring division whose quotient bits feed a Horner
// modular product of the Bezout coefficient in the same pass. Read gives one
// word per lane, and a word may wait on back-pressure. The input is taken
// only when the unit is idle; a finished word sits in an output register so
// the next lane carries on while it waits.
module residue_vector_alu_core
  import rvalu_pkg::*;
#(
  parameter int unsigned NUM_MODULI = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // operand_value[62:0], zero pad
  input  wire  [63:0] s_tdata_i,
  // kind[3:0], target_bank[4]
  input  wire  [4:0]  s_tuser_i,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  // lane_index[2:0], residue[33:3], banks_equal[34], a_less_than_b[35], zero pad
  output logic [39:0] m_tdata_o,
  output logic        m_tlast_o,
  output logic        m_tvalid_o,
  input  wire         m_tready_i,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [30:0] cfg_data_i
);

  localparam logic [2:0] LastLane = 3'(NUM_MODULI - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_RED, ST_OP, ST_LOAD, ST_WR, ST_MUL,
    ST_EUC, ST_DIVS, ST_EUPD, ST_EMIT, ST_NEXT
  } state_e;

  state_e      state_q;
  logic [3:0]  kind_q;
  logic        tgt_q;
  logic [62:0] val_q;
  logic [2:0]  lane_q;
  logic [5:0]  cnt_q;
  logic [30:0] sa_q, sb_q;
  logic [63:0] sh_q;
  logic [30:0] ra_q, rb_q, acc_q, mul_q, rem_q;
  logic [30:0] r0_q, r1_q, s0_q, s1_q;
  logic        eq_q, lt_q, dec_q;
  logic [30:0] mod_q [LaneSlots];
  logic [30:0] bank_a_q [LaneSlots];
  logic [30:0] bank_b_q [LaneSlots];

  logic [30:0] m_cur, a_v, b_v, h_v;
  logic        m_small;
  logic [31:0] div_t;
  logic        q_bit;
  logic        emit_valid, emit_ready;
  res_t        emit_res, out_res;

  assign m_cur   = mod_q[lane_q];
  assign m_small = (m_cur < 31'd2);
  assign a_v     = m_small ? '0 : ra_q;
  assign b_v     = m_small ? '0 : rb_q;
  assign h_v     = tgt_q ? b_v : a_v;
  assign div_t   = {rem_q, sa_q[30]};
  assign q_bit   = (div_t >= {1'b0, r1_q});

  assign s_tready_o = (state_q == ST_IDLE);
  assign emit_valid = (state_q == ST_EMIT);

  always_comb begin
    emit_res = '0;
    if (kind_q == KIND_CMP) begin
      emit_res.banks_equal   = eq_q;
      emit_res.a_less_than_b = lt_q;
      emit_res.last_result   = 1'b1;
    end else begin
      emit_res.lane_index  = lane_q;
      emit_res.residue     = ra_q;
      emit_res.last_result = (lane_q == LastLane);
    end
  end

  // moduli
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LaneSlots; i++) mod_q[i] <= ModReset[i];
    end else if (cfg_we_i) begin
      mod_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_CLR;
      tgt_q   <= 1'b0;
      lane_q  <= '0;
      cnt_q   <= '0;
      eq_q    <= 1'b1;
      lt_q    <= 1'b0;
      dec_q   <= 1'b0;
      for (int i = 0; i < LaneSlots; i++) begin
        bank_a_q[i] <= '0;
        bank_b_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i) begin
            kind_q <= s_tuser_i[3:0];
            tgt_q  <= s_tuser_i[4];
            val_q  <= s_tdata_i[62:0];
            lane_q <= '0;
            eq_q   <= 1'b1;
            lt_q   <= 1'b0;
            dec_q  <= 1'b0;
            if (s_tuser_i[3:0] <= KIND_RD) state_q <= ST_START;
          end
        end
        ST_START: begin
          sa_q  <= bank_a_q[lane_q];
          sb_q  <= bank_b_q[lane_q];
          ra_q  <= '0;
          rb_q  <= '0;
          cnt_q <= '0;
          if (kind_q == KIND_CLR) begin
            if (tgt_q) bank_b_q[lane_q] <= '0;
            else       bank_a_q[lane_q] <= '0;
            state_q <= ST_NEXT;
          end else if (kind_q == KIND_LD) begin
            sh_q    <= {1'b0, val_q};
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_RED;
          end
        end
        ST_RED: begin
          ra_q  <= red_step(ra_q, sa_q[30], m_cur);
          rb_q  <= red_step(rb_q, sb_q[30], m_cur);
          sa_q  <= {sa_q[29:0], 1'b0};
          sb_q  <= {sb_q[29:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd30) state_q <= ST_OP;
        end
        ST_OP: begin
          cnt_q <= '0;
          // digit append restarts the accumulator for the 64-bit pass
          ra_q  <= (kind_q == KIND_DIG) ? '0 : a_v;
          case (kind_q)
            KIND_DIG: begin
              sh_q    <= ({33'd0, h_v} << 3) + ({33'd0, h_v} << 1) + {1'b0, val_q};
              state_q <= ST_LOAD;
            end
            KIND_ADD: begin
              bank_a_q[lane_q] <= m_small ? '0 : add_mod(a_v, b_v, m_cur);
              state_q <= ST_NEXT;
            end
            KIND_SUB: begin
              bank_a_q[lane_q] <= m_small ? '0 : sub_mod(a_v, b_v, m_cur);
              state_q <= ST_NEXT;
            end
            KIND_MUL: begin
              acc_q   <= '0;
              mul_q   <= b_v;
              state_q <= ST_MUL;
            end
            KIND_DIV: begin
              if (b_v == '0) begin
                bank_a_q[lane_q] <= '0;
                state_q <= ST_NEXT;
              end else begin
                r0_q    <= m_cur;
                r1_q    <= b_v;
                s0_q    <= '0;
                s1_q    <= 31'd1;
                state_q <= ST_EUC;
              end
            end
            KIND_CMP: begin
              if (a_v != b_v) begin
                eq_q <= 1'b0;
                if (!dec_q) begin
                  lt_q  <= (a_v < b_v);
                  dec_q <= 1'b1;
                end
              end
              state_q <= ST_NEXT;
            end
            KIND_RD: state_q <= ST_EMIT;
            default: state_q <= ST_NEXT;
          endcase
        end
        ST_LOAD: begin
          ra_q  <= red_step(ra_q, sh_q[63], m_cur);
          sh_q  <= {sh_q[62:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) state_q <= ST_WR;
        end
        ST_WR: begin
          if (tgt_q) bank_b_q[lane_q] <= m_small ? '0 : ra_q;
          else       bank_a_q[lane_q] <= m_small ? '0 : ra_q;
          state_q <= ST_NEXT;
        end
        ST_MUL: begin
          acc_q <= mm_step(acc_q, mul_q[30], ra_q, m_cur);
          mul_q <= {mul_q[29:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          // product done: store into A
          if (cnt_q == 6'd30) begin
            bank_a_q[lane_q] <= mm_step(acc_q, mul_q[30], ra_q, m_cur);
            state_q <= ST_NEXT;
          end
        end
        ST_EUC: begin
          cnt_q <= '0;
          acc_q <= '0;
          rem_q <= '0;
          if (r1_q == '0) begin
            mul_q   <= (r0_q == 31'd1) ? s0_q : '0;
            state_q <= ST_MUL;
          end else begin
            sa_q    <= r0_q;
            state_q <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          rem_q <= q_bit ? 31'(div_t - {1'b0, r1_q}) : div_t[30:0];
          acc_q <= mm_step(acc_q, q_bit, s1_q, m_cur);
          sa_q  <= {sa_q[29:0], 1'b0};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd30) state_q <= ST_EUPD;
        end
        ST_EUPD: begin
          r0_q    <= r1_q;
          r1_q    <= rem_q;
          s0_q    <= s1_q;
          s1_q    <= sub_mod(s0_q, acc_q, m_cur);
          state_q <= ST_EUC;
        end
        ST_EMIT: begin
          if (emit_ready) begin
            if (kind_q == KIND_CMP || lane_q == LastLane) begin
              state_q <= ST_IDLE;
            end else begin
              lane_q  <= lane_q + 3'd1;
              state_q <= ST_START;
            end
          end
        end
        ST_NEXT: begin
          if (lane_q == LastLane) begin
            state_q <= (kind_q == KIND_CMP) ? ST_EMIT : ST_IDLE;
          end else begin
            lane_q  <= lane_q + 3'd1;
            state_q <= ST_START;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  rvalu_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (emit_valid),
    .in_ready_o (emit_ready),
    .in_res_i   (emit_res),
    .out_valid_o(m_tvalid_o),
    .out_ready_i(m_tready_i),
    .out_res_o  (out_res)
  );

  assign m_tdata_o = {4'd0, out_res.a_less_than_b, out_res.banks_equal,
                      out_res.residue, out_res.lane_index};
  assign m_tlast_o = out_res.last_result;

endmodule
`default_nettype wire

FILE: hdl/rvalu_out_reg.sv
// Output holding register between the sequencer and the result stream.
`default_nettype none
module rvalu_out_reg
  import rvalu_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  res_t in_res_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output res_t out_res_o
);

  logic full_q;
  res_t res_q;

  assign in_ready_o  = !full_q || out_ready_i;
  assign out_valid_o = full_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_ready_o) begin
      full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_res_i;
    end
  end

endmodule
`default_nettype wire
